FILE: src/blb_pkg.sv
package blb_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int MAX_CAPACITY = 16;

  localparam int SLOT_W = 5;
  localparam int CNT_W  = 5;
  localparam int WORD_W = 32;
  localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDX_W  = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int DEPTH  = NUM_SLOTS * MAX_CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Command kinds
  localparam logic [2:0] K_CREATE   = 3'd0;
  localparam logic [2:0] K_APPEND   = 3'd1;
  localparam logic [2:0] K_DEL_LAST = 3'd2;
  localparam logic [2:0] K_DEL_VAL  = 3'd3;
  localparam logic [2:0] K_GROW     = 3'd4;
  localparam logic [2:0] K_READ     = 3'd5;
  localparam logic [2:0] K_SORT     = 3'd6;
  localparam logic [2:0] K_COUNT    = 3'd7;

  // Result status codes
  localparam logic [3:0] S_OK         = 4'd0;
  localparam logic [3:0] S_BAD_SLOT   = 4'd1;
  localparam logic [3:0] S_EXISTS     = 4'd2;
  localparam logic [3:0] S_BAD_SIZE   = 4'd3;
  localparam logic [3:0] S_NO_ROOM    = 4'd4;
  localparam logic [3:0] S_NONE       = 4'd5;
  localparam logic [3:0] S_FULL       = 4'd6;
  localparam logic [3:0] S_EMPTY      = 4'd7;
  localparam logic [3:0] S_NOT_FOUND  = 4'd8;
  localparam logic [3:0] S_BAD_GROWTH = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK,
    ST_DV_RD, ST_DV_CHK,
    ST_SH, ST_SH_RD, ST_SH_WR,
    ST_RD_RD, ST_RD_EMIT,
    ST_SO_RD, ST_SO_CHK, ST_SO_EMIT
  } state_t;

  typedef enum logic [2:0] {
    EM_CHECK, EM_WORD, EM_BEST, EM_NOTFOUND, EM_DEL_OK
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  apply;
    logic  idx_clr;
    logic  idx_inc;
    logic  rd;
    logic  shift_wr;
    logic  cnt_dec;
    logic  sort_init;
    logic  best_clr;
    logic  best_upd;
    logic  prev_take;
    logic  emit;
    emit_t sel;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       chk_final;
    logic       idx_last;
    logic       k_last;
    logic       match;
    logic       out_free;
  } sts_t;

endpackage

FILE: src/bounded_list_bank.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_kind, in_slot, in_amount, in_value
// out     | out_valid / out_ready| out_status, out_data, out_count, out_last
//
// One command at a time. Single-result commands are checked and emitted from the check state.
// Delete value reads and compares each word searched, then reads and writes each word shifted.
// Stored-order read reads then emits each word; ascending read makes one full scan
// of the n words per result, as the element memory has a single read port.
// Synchronous reset clears slot tables and control; the element memory is not cleared.
// A stalled output holds the controller; a new command is taken once the last
// result of the previous one is in the output register.
module bounded_list_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [4:0]          in_slot,
  input  logic signed [5:0]   in_amount,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_status,
  output logic signed [31:0]  out_data,
  output logic [4:0]          out_count,
  output logic                out_last
);
  import blb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  blb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  blb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_kind),
    .in_slot    (in_slot),
    .in_amount  (in_amount),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_last   (out_last)
  );

  // Never overwrite a result that has not been transferred
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result emitted into a busy output register");

  // Memory read and shift write never share a cycle
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && cmd.shift_wr))
    else $error("read and shift write in one cycle");

  // An accepted command blocks input for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a command is in progress");

  // Error results are always single
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != S_OK) |-> out_last)
    else $error("error result without last");

endmodule

FILE: src/blb_ctrl.sv
module blb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  blb_pkg::sts_t sts,
  output blb_pkg::cmd_t cmd
);
  import blb_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = EM_CHECK;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.chk_final) begin
          if (sts.out_free) begin
            cmd.apply = 1'b1;
            cmd.emit  = 1'b1;
            cmd.sel   = EM_CHECK;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.idx_clr = 1'b1;
          case (sts.kind)
            K_DEL_VAL: state_nxt = ST_DV_RD;
            K_READ:    state_nxt = ST_RD_RD;
            default: begin
              cmd.sort_init = 1'b1;
              cmd.best_clr  = 1'b1;
              state_nxt     = ST_SO_RD;
            end
          endcase
        end
      end
      // Search for the first matching word
      ST_DV_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_DV_CHK;
      end
      ST_DV_CHK: begin
        if (sts.match) begin
          state_nxt = ST_SH;
        end else if (!sts.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_DV_RD;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_NOTFOUND;
          state_nxt = ST_IDLE;
        end
      end
      // Shift later words down by one
      ST_SH: begin
        if (!sts.idx_last) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SH_RD;
        end else if (sts.out_free) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit    = 1'b1;
          cmd.sel     = EM_DEL_OK;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SH_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = ST_SH;
      end
      // Stored-order readout
      ST_RD_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_WORD;
          if (sts.idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_RD_RD;
          end
        end
      end
      // Ascending readout: one full scan per result
      ST_SO_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SO_CHK;
      end
      ST_SO_CHK: begin
        cmd.best_upd = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_SO_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_SO_RD;
        end
      end
      ST_SO_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_BEST;
          if (sts.k_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.prev_take = 1'b1;
            cmd.best_clr  = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_nxt     = ST_SO_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/blb_dp.sv
module blb_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  blb_pkg::cmd_t       cmd,
  output blb_pkg::sts_t       sts,
  input  logic [2:0]          in_kind,
  input  logic [4:0]          in_slot,
  input  logic signed [5:0]   in_amount,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_status,
  output logic signed [31:0]  out_data,
  output logic [4:0]          out_count,
  output logic                out_last
);
  import blb_pkg::*;

  // Latched item
  logic [2:0]               kind_r;
  logic [SLOT_W-1:0]        slot_r;
  logic signed [5:0]        amount_r;
  logic signed [WORD_W-1:0] value_r;

  // Slot tables and element memory
  logic                     present_r  [NUM_SLOTS];
  logic [CNT_W-1:0]         capacity_r [NUM_SLOTS];
  logic [CNT_W-1:0]         count_r    [NUM_SLOTS];
  logic signed [WORD_W-1:0] mem        [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;

  // Walk and sort registers
  logic [IDX_W-1:0]         idx_r, k_r, best_idx_r, prev_idx_r;
  logic signed [WORD_W-1:0] best_val_r, prev_val_r;
  logic                     best_found_r, have_prev_r;

  // Output register
  logic                     ovalid_r, olast_r;
  logic [3:0]               ostatus_r;
  logic signed [WORD_W-1:0] odata_r;
  logic [CNT_W-1:0]         ocount_r;

  logic                     slot_ok;
  logic [SIDX_W-1:0]        s;
  logic                     pres;
  logic [CNT_W-1:0]         cap, cnt;
  logic [ADDR_W-1:0]        base, rd_addr, wr_addr;
  logic signed [7:0]        amt8, fin8;
  logic [3:0]               chk_status;
  logic [CNT_W-1:0]         chk_count;
  logic                     chk_final, chk_ok;
  logic                     we;
  logic signed [WORD_W-1:0] wdata;
  logic                     elig, better, out_free;

  assign slot_ok = (slot_r != '0) && (slot_r <= SLOT_W'(NUM_SLOTS));
  assign s       = SIDX_W'(slot_r - SLOT_W'(1));
  assign pres    = present_r[s];
  assign cap     = capacity_r[s];
  assign cnt     = count_r[s];
  assign base    = ADDR_W'(s) * ADDR_W'(MAX_CAPACITY);
  assign amt8    = {{2{amount_r[5]}}, amount_r};
  assign fin8    = $signed({3'b000, cap}) + amt8;

  // Checks in command order
  always_comb begin
    chk_status = S_OK;
    chk_count  = cnt;
    chk_final  = 1'b1;
    if (!slot_ok) begin
      chk_status = S_BAD_SLOT;
      chk_count  = '0;
    end else begin
      case (kind_r)
        K_CREATE: begin
          if (pres) chk_status = S_EXISTS;
          else if (amt8 < 8'sd1) chk_status = S_BAD_SIZE;
          else if (amt8 > 8'(MAX_CAPACITY)) chk_status = S_NO_ROOM;
          else chk_count = '0;
        end
        K_GROW: begin
          if (fin8 > 8'(MAX_CAPACITY)) chk_status = S_NO_ROOM;
          else if (!pres) chk_status = S_NONE;
          else if (amt8 < 8'sd0) chk_status = S_BAD_GROWTH;
        end
        default: begin
          if (!pres) begin
            chk_status = S_NONE;
          end else if (kind_r == K_APPEND) begin
            if (cnt >= cap || cnt >= CNT_W'(MAX_CAPACITY)) chk_status = S_FULL;
            else chk_count = cnt + CNT_W'(1);
          end else if (kind_r == K_SORT) begin
            chk_final = (cnt == '0);
          end else if (cnt == '0) begin
            chk_status = S_EMPTY;
          end else begin
            case (kind_r)
              K_DEL_LAST: chk_count = cnt - CNT_W'(1);
              K_DEL_VAL:  chk_final = 1'b0;
              K_READ:     chk_final = 1'b0;
              default:    chk_count = cnt;
            endcase
          end
        end
      endcase
    end
  end

  assign chk_ok = cmd.apply && (chk_status == S_OK);

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      slot_r   <= in_slot;
      amount_r <= in_amount;
      value_r  <= in_value;
    end
  end

  // Update slot tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        present_r[i]  <= 1'b0;
        capacity_r[i] <= '0;
        count_r[i]    <= '0;
      end
    end else if (chk_ok) begin
      case (kind_r)
        K_CREATE: begin
          present_r[s]  <= 1'b1;
          capacity_r[s] <= CNT_W'(amt8);
          count_r[s]    <= '0;
        end
        K_GROW:     capacity_r[s] <= CNT_W'(fin8);
        K_APPEND:   count_r[s]    <= cnt + CNT_W'(1);
        K_DEL_LAST: count_r[s]    <= cnt - CNT_W'(1);
        default: ;
      endcase
    end else if (cmd.cnt_dec) begin
      count_r[s] <= cnt - CNT_W'(1);
    end
  end

  // Element memory: one write, one registered read
  assign we      = (chk_ok && kind_r == K_APPEND) || cmd.shift_wr;
  assign wr_addr = cmd.shift_wr ? base + ADDR_W'(idx_r) - ADDR_W'(1)
                                : base + ADDR_W'(cnt[IDX_W-1:0]);
  assign wdata   = cmd.shift_wr ? rdata_r : value_r;
  assign rd_addr = base + ADDR_W'(idx_r);

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wdata;
    if (cmd.rd) rdata_r <= mem[rd_addr];
  end

  // Walk index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
  end

  // Ascending selection: smallest (word, position) above the previous pick
  assign elig   = !have_prev_r || (rdata_r > prev_val_r) ||
                  ((rdata_r == prev_val_r) && (idx_r > prev_idx_r));
  assign better = !best_found_r || (rdata_r < best_val_r);

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      have_prev_r <= 1'b0;
      k_r         <= '0;
    end else if (cmd.prev_take) begin
      have_prev_r <= 1'b1;
      prev_val_r  <= best_val_r;
      prev_idx_r  <= best_idx_r;
      k_r         <= k_r + IDX_W'(1);
    end
    if (cmd.best_clr) begin
      best_found_r <= 1'b0;
    end else if (cmd.best_upd && elig && better) begin
      best_found_r <= 1'b1;
      best_val_r   <= rdata_r;
      best_idx_r   <= idx_r;
    end
  end

  // Output register
  assign out_free = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        EM_WORD: begin
          ostatus_r <= S_OK;
          odata_r   <= rdata_r;
          ocount_r  <= cnt;
          olast_r   <= sts.idx_last;
        end
        EM_BEST: begin
          ostatus_r <= S_OK;
          odata_r   <= best_val_r;
          ocount_r  <= cnt;
          olast_r   <= sts.k_last;
        end
        EM_NOTFOUND: begin
          ostatus_r <= S_NOT_FOUND;
          odata_r   <= '0;
          ocount_r  <= cnt;
          olast_r   <= 1'b1;
        end
        EM_DEL_OK: begin
          ostatus_r <= S_OK;
          odata_r   <= '0;
          ocount_r  <= cnt - CNT_W'(1);
          olast_r   <= 1'b1;
        end
        default: begin
          ostatus_r <= chk_status;
          odata_r   <= '0;
          ocount_r  <= chk_count;
          olast_r   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid  = ovalid_r;
  assign out_status = ostatus_r;
  assign out_data   = odata_r;
  assign out_count  = ocount_r;
  assign out_last   = olast_r;

  // Status to the controller
  assign sts.kind      = kind_r;
  assign sts.chk_final = chk_final;
  assign sts.idx_last  = ({1'b0, idx_r} + (IDX_W+1)'(1)) == (IDX_W+1)'(cnt);
  assign sts.k_last    = ({1'b0, k_r} + (IDX_W+1)'(1)) == (IDX_W+1)'(cnt);
  assign sts.match     = (rdata_r == value_r);
  assign sts.out_free  = out_free;

endmodule
